// ----- sv/pgcm_pkg.sv -----
// ----------------------------------------------------------------------------
// pgcm_pkg
// Shared constants and types for the palette gradient color mapper.
// ----------------------------------------------------------------------------
package pgcm_pkg;

  localparam int PALETTE_MAX_DEF   = 5;
  localparam int POS_FRAC_BITS_DEF = 16;

  // palette entries reachable through the register port
  localparam int PAL_REGS = 5;

  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL0    = 3'd2;

  localparam logic [COLOR_W-1:0] WHITE_BGR  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] PAL0_RESET = 24'h0000FF;
  localparam logic [COLOR_W-1:0] PAL1_RESET = 24'hFF0000;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

  // per-stage load enables of the datapath pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pgcm_en_t;

endpackage

// ----- sv/pgcm_cfg.sv -----
// ----------------------------------------------------------------------------
// pgcm_cfg
// Configuration register file: mode, palette count and palette entries.
// ----------------------------------------------------------------------------
module pgcm_cfg #(
  parameter int PaletteMax = pgcm_pkg::PALETTE_MAX_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [pgcm_pkg::CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [pgcm_pkg::COLOR_W-1:0]                    cfg_data_i,
  output logic                                            rainbow_o,
  output logic [pgcm_pkg::COUNT_W-1:0]                    count_o,
  output logic [PaletteMax-1:0][pgcm_pkg::COLOR_W-1:0]    palette_o
);
  import pgcm_pkg::*;

  logic                                 rainbow_q;
  logic [COUNT_W-1:0]                   count_q;
  logic [PaletteMax-1:0][COLOR_W-1:0]   palette_q;
  logic                                 wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rainbow_q <= 1'b0;
      count_q   <= COUNT_RESET;
      for (int k = 0; k < PaletteMax; k++) begin
        if (k == 0) begin
          palette_q[k] <= PAL0_RESET;
        end else if (k == 1) begin
          palette_q[k] <= PAL1_RESET;
        end else begin
          palette_q[k] <= '0;
        end
      end
    end else if (wr) begin
      if (cfg_index_i == CFG_RAINBOW) begin
        rainbow_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CFG_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end
      for (int k = 0; k < PaletteMax; k++) begin
        if (k < PAL_REGS && cfg_index_i == CFG_IDX_W'(int'(CFG_PAL0) + k)) begin
          palette_q[k] <= cfg_data_i;
        end
      end
    end
  end

  assign rainbow_o = rainbow_q;
  // counts above the store depth saturate
  assign count_o   = (count_q > COUNT_W'(PaletteMax)) ? COUNT_W'(PaletteMax) : count_q;
  assign palette_o = palette_q;

endmodule

// ----- sv/pgcm_hue.sv -----
// ----------------------------------------------------------------------------
// pgcm_hue
// Three-stage hue wheel: position scaling, sector split, ramp scaling; channel packing is combinational.
// ----------------------------------------------------------------------------
module pgcm_hue #(
  parameter int PosFracBits = pgcm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  pgcm_pkg::pgcm_en_t            en_i,
  input  logic [PosFracBits:0]          pos_i,
  output logic [pgcm_pkg::COLOR_W-1:0]  color_o
);
  import pgcm_pkg::*;

  localparam int TW = PosFracBits + 4;
  localparam int XW = PosFracBits + 1;
  localparam int PW = PosFracBits + 9;
  localparam logic [3:0] HUE_SECTORS = 4'd6;
  localparam logic [XW-1:0] ONE = {1'b1, {PosFracBits{1'b0}}};

  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;

  localparam logic [CHAN_W-1:0] FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] ZERO = 8'h00;

  logic [TW-1:0]     t_d, t_q;
  logic [3:0]        hi;
  logic [2:0]        sec_d, sec_q, sec3_q;
  logic [XW-1:0]     xf_d, xf_q;
  logic [PW-1:0]     prod;
  logic [CHAN_W-1:0] x_d, x_q;

  // position times six: hue counted in 60-degree sectors
  assign t_d = TW'({pos_i, 2'b00}) + TW'({pos_i, 1'b0});

  assign hi    = t_q[TW-1:PosFracBits];
  assign sec_d = (hi >= HUE_SECTORS) ? 3'(hi - HUE_SECTORS) : hi[2:0];
  assign xf_d  = sec_d[0] ? (ONE - {1'b0, t_q[PosFracBits-1:0]})
                          : {1'b0, t_q[PosFracBits-1:0]};

  // xf * 255
  assign prod = PW'({xf_q, 8'h00}) - PW'(xf_q);
  assign x_d  = prod[PosFracBits+7:PosFracBits];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      t_q <= t_d;
    end
    if (en_i.s2) begin
      sec_q <= sec_d;
      xf_q  <= xf_d;
    end
    if (en_i.s3) begin
      sec3_q <= sec_q;
      x_q    <= x_d;
    end
  end

  always_comb begin
    case (sec3_q)
      SEC_RED_YEL: color_o = {ZERO, x_q, FULL};
      SEC_YEL_GRN: color_o = {ZERO, FULL, x_q};
      SEC_GRN_CYN: color_o = {x_q, FULL, ZERO};
      SEC_CYN_BLU: color_o = {FULL, x_q, ZERO};
      SEC_BLU_MAG: color_o = {FULL, ZERO, x_q};
      default:     color_o = {x_q, ZERO, FULL};
    endcase
  end

endmodule

// ----- sv/pgcm_lerp.sv -----
// ----------------------------------------------------------------------------
// pgcm_lerp
// Three-stage palette interpolation: segment scale, entry select, weighting.
// ----------------------------------------------------------------------------
module pgcm_lerp #(
  parameter int PaletteMax  = pgcm_pkg::PALETTE_MAX_DEF,
  parameter int PosFracBits = pgcm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  pgcm_pkg::pgcm_en_t                            en_i,
  input  logic [PosFracBits:0]                          pos_i,
  input  logic [pgcm_pkg::COUNT_W-1:0]                  count_i,
  input  logic [PaletteMax-1:0][pgcm_pkg::COLOR_W-1:0]  palette_i,
  output logic [pgcm_pkg::COLOR_W-1:0]                  color_o
);
  import pgcm_pkg::*;

  localparam int SW = PosFracBits + 4;
  localparam int FW = PosFracBits + 1;
  localparam int NW = PosFracBits + 9;
  localparam int IW = $clog2(PaletteMax);
  localparam logic [FW-1:0] ONE = {1'b1, {PosFracBits{1'b0}}};

  logic [COUNT_W-1:0]       nm1_in;
  logic [SW-1:0]            s_d, s_q;
  logic [COUNT_W-1:0]       n_q, nm1;
  logic [3:0]               hi;
  logic [IW-1:0]            sel1, sel2;
  logic [COLOR_W-1:0]       ent1, ent2;
  logic [COLOR_W-1:0]       c1_d, c2_d, c1_q, c2_q;
  logic [PosFracBits-1:0]   frac_d, frac_q;
  logic [FW-1:0]            wf;
  logic [2:0][NW-1:0]       num_d, num_q;

  assign nm1_in = count_i - COUNT_W'(1);
  assign s_d    = SW'(pos_i) * SW'(nm1_in);

  assign nm1 = n_q - COUNT_W'(1);
  assign hi  = s_q[SW-1:PosFracBits];

  always_comb begin
    c1_d   = WHITE_BGR;
    c2_d   = WHITE_BGR;
    frac_d = '0;
    sel1   = hi[IW-1:0];
    sel2   = IW'(hi[IW-1:0] + IW'(1));
    if (n_q != '0 && hi >= 4'(nm1)) begin
      // at or past the end, or a single entry: hold the last entry in use
      sel1 = nm1[IW-1:0];
      sel2 = nm1[IW-1:0];
    end
    ent1 = '0;
    ent2 = '0;
    for (int k = 0; k < PaletteMax; k++) begin
      if (sel1 == IW'(k)) begin
        ent1 = palette_i[k];
      end
      if (sel2 == IW'(k)) begin
        ent2 = palette_i[k];
      end
    end
    if (n_q != '0) begin
      c1_d = ent1;
      c2_d = ent2;
      if (hi < 4'(nm1)) begin
        frac_d = s_q[PosFracBits-1:0];
      end
    end
  end

  assign wf = ONE - {1'b0, frac_q};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num_d[ch] = NW'(c1_q[ch*CHAN_W +: CHAN_W]) * NW'(wf)
                + NW'(c2_q[ch*CHAN_W +: CHAN_W]) * NW'(frac_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s_q <= s_d;
      n_q <= count_i;
    end
    if (en_i.s2) begin
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      frac_q <= frac_d;
    end
    if (en_i.s3) begin
      num_q <= num_d;
    end
  end

  assign color_o = {num_q[2][PosFracBits+7:PosFracBits],
                    num_q[1][PosFracBits+7:PosFracBits],
                    num_q[0][PosFracBits+7:PosFracBits]};

endmodule

// ----- sv/palette_gradient_color_mapper.sv -----
// ----------------------------------------------------------------------------
// palette_gradient_color_mapper
// Maps a gradient position to a packed 0xBBGGRR color, by hue wheel or by
// linear interpolation over a configured palette.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid_i/in_stall_o   position_i
//  output    out_valid_o/out_stall_i color_out_o
//  config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  Four register stages; a position passes s1, s2, s3 and the output register.
//  The rate is set by the shared stage enables, one position per clock while
//  the output is not stalled. Reset clears the valid bits and puts the config
//  registers at their reset values; the datapath registers have no reset. A
//  stall at the output backs up stage by stage; empty stages keep filling, so
//  the input stalls only once the pipe is full.
module palette_gradient_color_mapper #(
  parameter int PaletteMax  = pgcm_pkg::PALETTE_MAX_DEF,
  parameter int PosFracBits = pgcm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PosFracBits:0]            position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pgcm_pkg::COLOR_W-1:0]    color_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pgcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgcm_pkg::COLOR_W-1:0]    cfg_data_i
);
  import pgcm_pkg::*;

  logic                               rainbow;
  logic [COUNT_W-1:0]                 count;
  logic [PaletteMax-1:0][COLOR_W-1:0] palette;
  pgcm_en_t                           en;
  logic                               en_out;
  logic                               v1_q, v2_q, v3_q, vo_q;
  logic                               m1_q, m2_q, m3_q;
  logic [COLOR_W-1:0]                 hue_color, lerp_color;
  logic [COLOR_W-1:0]                 color_d, color_q;

  pgcm_cfg #(.PaletteMax(PaletteMax)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rainbow_o  (rainbow),
    .count_o    (count),
    .palette_o  (palette)
  );

  // a stage loads when it is empty or its successor loads
  assign en_out = ~vo_q | ~out_stall_i;
  assign en.s3  = ~v3_q | en_out;
  assign en.s2  = ~v2_q | en.s3;
  assign en.s1  = ~v1_q | en.s2;
  assign in_stall_o = ~en.s1;

  pgcm_hue #(.PosFracBits(PosFracBits)) u_hue (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_i  (position_i),
    .color_o(hue_color)
  );

  pgcm_lerp #(.PaletteMax(PaletteMax), .PosFracBits(PosFracBits)) u_lerp (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_i    (position_i),
    .count_i  (count),
    .palette_i(palette),
    .color_o  (lerp_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en_out) vo_q <= v3_q;
    end
  end

  assign color_d = m3_q ? hue_color : lerp_color;

  always_ff @(posedge clk_i) begin
    if (en.s1) m1_q <= rainbow;
    if (en.s2) m2_q <= m1_q;
    if (en.s3) m3_q <= m2_q;
    if (en_out) color_q <= color_d;
  end

  assign out_valid_o = vo_q;
  assign color_out_o = color_q;

endmodule

// ----- sv/pgcm_checker.sv -----
// ----------------------------------------------------------------------------
// pgcm_checker
// Port-level checks on the color mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pgcm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [pgcm_pkg::COLOR_W-1:0]   color_out_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(color_out_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled, occupied output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an accepted position reaches the output when no output stall holds it on the way
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_valid_i, 4) && !$past(in_stall_o, 4) &&
     $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1) &&
     !$past(out_stall_i, 3) && !$past(out_stall_i, 2) && !$past(out_stall_i, 1))
    |-> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind palette_gradient_color_mapper pgcm_checker u_pgcm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .color_out_o(color_out_o)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for palette_gradient_color_mapper: positions go in
// through a queue-fed driver, colors are checked against an in-bench color
// predictor across hue wheel and palette settings and several stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import pgcm_pkg::*;

  localparam int FracBits = POS_FRAC_BITS_DEF;
  localparam int PosW     = FracBits + 1;
  localparam int unsigned OnePos = 1 << FracBits;
  localparam int unsigned PosMax = (1 << PosW) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int HoldCycles = 64;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [PosW-1:0]      position    = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [COLOR_W-1:0]   color_out;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_RAINBOW;
  logic [COLOR_W-1:0]   cfg_data    = '0;

  palette_gradient_color_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .position_i  (position),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .color_out_o (color_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // shadow copy of the register file
  logic               mdl_rainbow = 1'b0;
  logic [COUNT_W-1:0] mdl_count   = COUNT_RESET;
  logic [COLOR_W-1:0] mdl_pal [PALETTE_MAX_DEF] = '{PAL0_RESET, PAL1_RESET, '0, '0, '0};

  logic [PosW-1:0]    position_q[$];
  logic [COLOR_W-1:0] pending_colors[$];
  int unsigned        items_queued = 0;
  int unsigned        items_taken  = 0;
  int unsigned        err_count    = 0;
  int unsigned        snd_idle_pct = 0;
  int unsigned        rcv_stall_pct = 0;
  int unsigned        hold_reqs = 0;
  int unsigned        hold_seen = 0;
  int unsigned        hold_left = 0;
  logic               in_fire  = 1'b0;
  logic               cfg_fire = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [COLOR_W-1:0] hue_rgb(input logic [PosW-1:0] pos);
    int unsigned t, sector, f, xf;
    logic [CHAN_W-1:0] x;
    t = pos * 6;
    sector = (t >> FracBits) % 6;
    f = t & (OnePos - 1);
    xf = sector[0] ? OnePos - f : f;
    x = CHAN_W'((xf * 255) >> FracBits);
    // packed {b, g, r}
    case (sector)
      0: return {8'h00, x, 8'hFF};
      1: return {8'h00, 8'hFF, x};
      2: return {x, 8'hFF, 8'h00};
      3: return {8'hFF, x, 8'h00};
      4: return {8'hFF, 8'h00, x};
      default: return {x, 8'h00, 8'hFF};
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] lerp_palette(input logic [PosW-1:0] pos);
    int unsigned n, s, idx, frac, k;
    logic [COLOR_W-1:0] c1, c2, res;
    n = (mdl_count > PALETTE_MAX_DEF) ? PALETTE_MAX_DEF : mdl_count;
    if (n == 0) return WHITE_BGR;
    if (n == 1) return mdl_pal[0];
    s = pos * (n - 1);
    idx = s >> FracBits;
    frac = s & (OnePos - 1);
    if (idx >= n - 1) return mdl_pal[n-1];
    c1 = mdl_pal[idx];
    c2 = mdl_pal[idx+1];
    for (k = 0; k < 3; k++) begin
      res[k*CHAN_W +: CHAN_W] = CHAN_W'((c1[k*CHAN_W +: CHAN_W] * (OnePos - frac)
                                        + c2[k*CHAN_W +: CHAN_W] * frac) >> FracBits);
    end
    return res;
  endfunction

  function automatic logic [COLOR_W-1:0] map_position(input logic [PosW-1:0] pos);
    return mdl_rainbow ? hue_rgb(pos) : lerp_palette(pos);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] data);
    if (idx == CFG_RAINBOW) begin
      mdl_rainbow = data[0];
    end else if (idx == CFG_COUNT) begin
      mdl_count = data[COUNT_W-1:0];
    end else if (idx >= CFG_PAL0 && idx < CFG_PAL0 + PAL_REGS) begin
      mdl_pal[idx - CFG_PAL0] = data;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // monitor: input, config and output transactions at the rising edge
  always @(posedge clk_i) begin
    logic [COLOR_W-1:0] want;
    in_fire  <= in_valid && !in_stall;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        pending_colors = {pending_colors, map_position(position)};
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pending_colors.size() == 0) begin
          report_mismatch($sformatf("unexpected color %06h", color_out));
        end else begin
          want = pending_colors.pop_front();
          if (color_out !== want)
            report_mismatch($sformatf("color_out %06h, want %06h", color_out, want));
        end
      end
    end
  end

  // driver: new position only once the previous one was taken
  always @(negedge clk_i) begin
    if (!in_valid || in_fire) begin
      if (position_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        position <= position_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input int unsigned s_idle, input int unsigned r_stall);
    @(posedge clk_i);
    snd_idle_pct  = s_idle;
    rcv_stall_pct = r_stall;
  endtask

  task automatic offer(input logic [PosW-1:0] pos);
    position_q = {position_q, pos};
    items_queued++;
  endtask

  function automatic logic [PosW-1:0] pick_position(input int unsigned seg);
    int unsigned r, base, p;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      p = $urandom_range(0, OnePos);
    end else if (r < 75) begin
      // near a segment or sector boundary
      base = ($urandom_range(0, seg) * OnePos) / seg;
      p = base + $urandom_range(0, 4);
      p = (p >= 2) ? p - 2 : 0;
    end else if (r < 92) begin
      p = $urandom_range(0, PosMax);
    end else begin
      case ($urandom_range(0, 3))
        0: p = 0;
        1: p = OnePos - 1;
        2: p = OnePos;
        default: p = PosMax;
      endcase
    end
    if (p > PosMax) p = PosMax;
    return PosW'(p);
  endfunction

  task automatic random_items(input int unsigned n, input int unsigned seg);
    repeat (n) offer(pick_position(seg));
  endtask

  task automatic drain();
    do @(negedge clk_i); while (items_taken != items_queued || pending_colors.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_palette(input bit extremes);
    int i;
    for (i = 0; i < PAL_REGS; i++) begin
      if (extremes) reg_write(CFG_IDX_W'(CFG_PAL0 + i), (i % 2) ? WHITE_BGR : '0);
      else          reg_write(CFG_IDX_W'(CFG_PAL0 + i), COLOR_W'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: red to blue over two entries
    start_phase(0, 0);
    offer(0); offer(1); offer(32767); offer(32768);
    offer(65535); offer(65536); offer(65537); offer(PosMax);
    drain();

    // hue wheel, sector edges and wrap past 1.0; upper data bits ignored
    reg_write(CFG_RAINBOW, 24'h5A5A5B);
    start_phase(0, 0);
    offer(0); offer(10922); offer(10923); offer(21845); offer(21846);
    offer(32768); offer(43690); offer(43691); offer(54613); offer(65535);
    offer(65536); offer(98304); offer(PosMax);
    drain();

    start_phase(0, 0);
    random_items(150, 6);
    drain();

    // empty palette gives white
    reg_write(CFG_RAINBOW, 24'hFFFFFE);
    reg_write(CFG_COUNT, 24'hFFFFF8);
    start_phase(55, 0);
    random_items(40, 1);
    drain();

    // single entry
    reg_write(CFG_COUNT, 24'h000001);
    reg_write(CFG_PAL0, COLOR_W'($urandom));
    start_phase(0, 55);
    random_items(40, 1);
    drain();

    // full palette, long output hold-off so the pipe backs up
    load_palette(1'b0);
    reg_write(CFG_COUNT, 24'hFFFFFD);
    start_phase(10, 10);
    random_items(150, 4);
    repeat (20) @(posedge clk_i);
    hold_reqs++;
    drain();

    // count above the palette size saturates
    load_palette(1'b1);
    reg_write(CFG_COUNT, 24'h000007);
    start_phase(55, 0);
    random_items(80, 4);
    drain();

    // unused index must not disturb anything
    load_palette(1'b0);
    reg_write(CFG_COUNT, 24'h000003);
    reg_write(CFG_UNUSED, COLOR_W'($urandom));
    start_phase(0, 55);
    random_items(100, 2);
    drain();

    reg_write(CFG_COUNT, 24'h000004);
    reg_write(CFG_IDX_W'(CFG_PAL0 + 1), WHITE_BGR);
    reg_write(CFG_IDX_W'(CFG_PAL0 + 2), '0);
    start_phase(0, 0);
    random_items(80, 3);
    drain();

    reg_write(CFG_COUNT, 24'h000006);
    reg_write(CFG_RAINBOW, 24'h000001);
    start_phase(10, 10);
    random_items(60, 6);
    drain();

    if (pending_colors.size() != 0)
      report_mismatch($sformatf("%0d colors never came out", pending_colors.size()));
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- palette_gradient_color_mapper.f -----
sv/pgcm_pkg.sv
sv/pgcm_cfg.sv
sv/pgcm_hue.sv
sv/pgcm_lerp.sv
sv/palette_gradient_color_mapper.sv
sv/pgcm_checker.sv
dv/tb.sv
